// ===== design/amss_pkg.sv =====
// Package for the above-mean sorted select block: widths, batch size,
// controller/datapath command and status types, and the mean-test helper.
// No dependencies.
package amss_pkg;

    localparam int COUNT  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(COUNT);
    localparam int SUM_W  = DATA_W + $clog2(COUNT);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam sum_t COUNT_S = SUM_W'(COUNT);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_item;
        logic sel0;
        logic sel1;
    } status_t;

    // A value lies strictly above the mean when value*COUNT exceeds the sum.
    function automatic logic above_mean(input data_t v, input sum_t s);
        sum_t ext;
        sum_t prod;
        ext  = SUM_W'(v);
        prod = ext * COUNT_S;
        return prod > s;
    endfunction

endpackage

// ===== design/amss_sample_if.sv =====
// Input stream interface carrying one batch sample per transaction.
// Depends on nothing.
interface amss_sample_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== design/amss_select_if.sv =====
// Output stream interface carrying one selected value per transaction.
// Depends on nothing.
interface amss_select_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    selected_value;
    logic                  is_final;

    modport source (output valid, output selected_value, output is_final, input ready);
    modport sink   (input valid, input selected_value, input is_final, output ready);
endinterface

// ===== design/amss_datapath.sv =====
// Datapath: sorted insertion cell chain, running sum, fill count, output register.
// Depends on amss_pkg.
module amss_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  amss_pkg::cmd_t        cmd,
    output amss_pkg::status_t     status,
    input  amss_pkg::data_t       sample_value,
    output amss_pkg::data_t       selected_value,
    output logic                  is_final
);
    import amss_pkg::*;

    data_t             cells_reg [COUNT];
    data_t             cells_next [COUNT];
    logic [COUNT-1:0]  gt;
    sum_t              sum_reg, sum_next;
    cnt_t              count_reg, count_next;
    data_t             sel_value_reg;
    logic              final_reg;

    // A cell takes part in the comparison only once it holds a sample of this
    // batch; empty cells act as the lowest value so the new one lands there.
    always_comb
    begin
        for (int i = 0; i < COUNT; i++)
        begin
            gt[i] = (CNT_W'(i) >= count_reg) || (sample_value > cells_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < COUNT; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        if (cmd.load)
        begin
            if (gt[0])
            begin
                cells_next[0] = sample_value;
            end
            for (int i = 1; i < COUNT; i++)
            begin
                if (gt[i])
                begin
                    cells_next[i] = gt[i-1] ? cells_reg[i-1] : sample_value;
                end
            end
        end
        else if (cmd.emit)
        begin
            // The chain moves up by one so the next candidate sits at the head.
            for (int i = 0; i < COUNT-1; i++)
            begin
                cells_next[i] = cells_reg[i+1];
            end
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (cmd.load)
        begin
            sum_next   = sum_reg + SUM_W'(sample_value);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < COUNT; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.emit)
        begin
            sel_value_reg <= cells_reg[0];
            final_reg     <= !status.sel1;
        end
    end

    assign status.last_item = (count_reg == CNT_W'(COUNT-1));
    assign status.sel0      = above_mean(cells_reg[0], sum_reg);
    assign status.sel1      = above_mean(cells_reg[1], sum_reg);

    assign selected_value = sel_value_reg;
    assign is_final       = final_reg;

endmodule

// ===== design/amss_ctrl.sv =====
// Controller: load/emit state machine and the output valid flag.
// Depends on amss_pkg.
module amss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output amss_pkg::cmd_t        cmd,
    input  amss_pkg::status_t     status
);
    import amss_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.last_item)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // Only reached with nothing selected when the batch is all equal.
                if (!status.sel0)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.sel1)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_last_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.last_item) |=> (state_reg == ST_EMIT))
        else $error("last sample of a batch did not start emission");

    a_emit_selected: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.sel0)
        else $error("emitted a value that is not above the mean");

    a_clear_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (state_reg == ST_LOAD))
        else $error("batch cleared without returning to loading");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.emit)
        else $error("output register overwritten while stalled");

endmodule

// ===== design/above_mean_sorted_select_core.sv =====
// Top level of the above-mean sorted select block: wires the controller and
// datapath to the stream interfaces. Depends on amss_pkg, amss_ctrl,
// amss_datapath, amss_sample_if and amss_select_if.
//
//   Channel     | Dir | Transaction content
//   ------------+-----+------------------------------------------
//   samples     | in  | sample_value (signed 32)
//   selections  | out | selected_value (signed 32), is_final
//
// Samples are taken one per cycle; each goes into a sorted cell chain.
// After the batch's last sample, one selected value per cycle leaves from
// the head of the chain while the output is taken, largest first.
// A batch with no value above the mean gives nothing; its emit state only clears it.
// A stalled output holds the result register; no samples are taken until
// emission ends. Reset clears the sum, fill count, state and output valid.
module above_mean_sorted_select_core (
    input  logic           clk,
    input  logic           rst_n,
    amss_sample_if.sink    samples,
    amss_select_if.source  selections
);
    import amss_pkg::*;

    cmd_t    cmd;
    status_t status;

    amss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (selections.valid),
        .out_ready (selections.ready),
        .cmd       (cmd),
        .status    (status)
    );

    amss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_value   (samples.sample_value),
        .selected_value (selections.selected_value),
        .is_final       (selections.is_final)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for above_mean_sorted_select_core: sends batches of signed samples
// and checks every selected value and its final flag against an in-bench predictor.
// Depends on amss_pkg, amss_sample_if, amss_select_if and the core itself.
module tb_top;
    import amss_pkg::*;

    typedef struct {
        data_t value;
        logic  is_final;
    } selection_t;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_TIES,
        SHAPE_HIGH,
        SHAPE_LOW,
        SHAPE_ONE_LOW,
        SHAPE_ONE_HIGH,
        SHAPE_FLAT
    } batch_shape_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_STREAK
    } stall_mode_t;

    logic clk;
    logic rst_n;

    amss_sample_if samples();
    amss_select_if selections();

    above_mean_sorted_select_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .selections (selections)
    );

    selection_t pending_sel[$];
    data_t      batch_vals[$];
    longint     batch_sum;
    int         errors;
    int         samples_sent;
    int         selections_seen;
    int         batches_done;
    int         empty_batches;
    int         burst_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // Adds one sample to the current batch; on the batch's last sample the values above
    // the mean are queued in descending order, using an exact integer comparison.
    function automatic void predict_selection(input data_t v);
        data_t      picked[$];
        data_t      x;
        int         j;
        selection_t s;
        batch_vals.insert(batch_vals.size(), v);
        batch_sum += longint'(v);
        if (batch_vals.size() < COUNT)
            return;
        foreach (batch_vals[i])
        begin
            x = batch_vals[i];
            if (longint'(x) * longint'(COUNT) > batch_sum)
            begin
                j = 0;
                while (j < picked.size() && picked[j] >= x)
                    j++;
                picked.insert(j, x);
            end
        end
        if (picked.size() == 0)
            empty_batches++;
        foreach (picked[i])
        begin
            s.value    = picked[i];
            s.is_final = (i == picked.size() - 1);
            pending_sel.insert(pending_sel.size(), s);
        end
        batch_vals.delete();
        batch_sum = 0;
        batches_done++;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    // The sender works in bursts, dropping valid for a random gap between them.
    task automatic send_sample(input data_t v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(1, 8);
        end
        samples.valid        <= 1'b1;
        samples.sample_value <= v;
        do
            @(posedge clk);
        while (!samples.ready);
        samples_sent++;
        predict_selection(v);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_batch(input data_t vals[$]);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    // Extremes of the field, ties at the top and a sum beyond the signed 32-bit range.
    task automatic test_extremes();
        data_t vals[$];
        vals = '{data_t'(32'h7FFF_FFFF), data_t'(32'h8000_0000), data_t'(32'hFFFF_FFFF),
                 data_t'(32'h0000_0000), data_t'(32'h7FFF_FFFF), data_t'(32'h0000_0001),
                 data_t'(32'h4000_0000), data_t'(32'h8000_0000), data_t'(32'hC000_0000),
                 data_t'(32'h5555_5555), data_t'(32'h7FFF_FFFF), data_t'(32'hAAAA_AAAA),
                 data_t'(32'h8000_0000), data_t'(32'h7FFF_FFFE), data_t'(32'h7FFF_FFFF),
                 data_t'(32'h0000_0001)};
        send_batch(vals);
    endtask

    // A batch of identical values has nothing above its mean and gives no transaction.
    task automatic test_all_equal();
        data_t vals[$];
        repeat (COUNT)
            vals.insert(vals.size(), data_t'(32'h8000_0000));
        send_batch(vals);
    endtask

    task automatic test_random_batches(input int n_batches);
        data_t        vals[$];
        data_t        base;
        data_t        elem;
        batch_shape_t shape;
        int           odd_pos;
        repeat (n_batches)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: shape = SHAPE_WIDE;
                3, 4:    shape = SHAPE_TIES;
                5:       shape = SHAPE_HIGH;
                6:       shape = SHAPE_LOW;
                7:       shape = SHAPE_ONE_LOW;
                8:       shape = SHAPE_ONE_HIGH;
                default: shape = SHAPE_FLAT;
            endcase
            base    = data_t'($urandom);
            odd_pos = $urandom_range(0, COUNT - 1);
            vals.delete();
            for (int i = 0; i < COUNT; i++)
            begin
                case (shape)
                    SHAPE_WIDE:     elem = data_t'($urandom);
                    SHAPE_TIES:     elem = base + data_t'($urandom_range(0, 3));
                    SHAPE_HIGH:     elem = data_t'(32'h7FFF_FFFF)
                                           - data_t'($urandom_range(0, 1000));
                    SHAPE_LOW:      elem = data_t'(32'h8000_0000)
                                           + data_t'($urandom_range(0, 1000));
                    SHAPE_ONE_LOW:  elem = (i == odd_pos) ? base - 1 : base;
                    SHAPE_ONE_HIGH: elem = (i == odd_pos) ? base + 1 : base;
                    default:        elem = base;
                endcase
                vals.insert(vals.size(), elem);
            end
            send_batch(vals);
        end
    endtask

    // The receiver changes its stall pattern after each span of random length.
    initial
    begin : sel_receiver
        stall_mode_t mode;
        int          span;
        int          hold;
        selections.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 48);
            hold = 0;
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  selections.ready <= 1'b1;
                    STALL_HALF:  selections.ready <= ($urandom_range(0, 1) == 1);
                    STALL_LIGHT: selections.ready <= ($urandom_range(0, 4) != 0);
                    default:
                    begin
                        if (hold == 0)
                            hold = $urandom_range(1, 7);
                        hold--;
                        selections.ready <= (hold == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : sel_checker
        selection_t want;
        if (rst_n && selections.valid && selections.ready)
        begin
            selections_seen++;
            if (pending_sel.size() == 0)
                report_mismatch($sformatf("unexpected selection %0d final %0b",
                                          selections.selected_value, selections.is_final));
            else
            begin
                want = pending_sel.pop_front();
                if (selections.selected_value !== want.value)
                    report_mismatch($sformatf("selected_value %0d, wanted %0d",
                                              selections.selected_value, want.value));
                if (selections.is_final !== want.is_final)
                    report_mismatch($sformatf("is_final %0b on %0d, wanted %0b",
                                              selections.is_final, want.value,
                                              want.is_final));
            end
        end
    end

    initial
    begin : main_seq
        samples.valid        = 1'b0;
        samples.sample_value = '0;
        rst_n                = 1'b0;
        errors               = 0;
        samples_sent         = 0;
        selections_seen      = 0;
        batches_done         = 0;
        empty_batches        = 0;
        burst_left           = 0;
        batch_sum            = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_all_equal();
        test_random_batches(18);
        samples.valid <= 1'b0;

        while (pending_sel.size() != 0)
            @(posedge clk);
        // An empty batch may still be finishing after the last transaction.
        repeat (20) @(posedge clk);
        if (pending_sel.size() != 0)
            report_mismatch($sformatf("%0d selections never arrived", pending_sel.size()));

        $display("tb_top: %0d samples in %0d batches, %0d selections checked",
                 samples_sent, batches_done, selections_seen);
        $display("tb_top: %0d batches had nothing above the mean", empty_batches);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
